### rtl/u8gm_pkg.sv
// Shared types and constants for the UTF-8 glyph map builder.
package u8gm_pkg;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] GLYPH_SEP   = 8'hFF;
    localparam logic [7:0] LEAD2_MASK  = 8'h1F;
    localparam logic [7:0] LEAD3_MASK  = 8'h0F;
    localparam logic [7:0] LEAD4_MASK  = 8'h07;
    localparam logic [7:0] CONT_MASK   = 8'h3F;

    // Byte class as seen by the front, before the pending count is known
    typedef enum logic [2:0] {
        OP_GLYPH,
        OP_CHAR1,
        OP_LEAD2,
        OP_LEAD3,
        OP_LEAD4,
        OP_BADLEAD
    } t_byte_op;

    // One queued beat
    typedef struct packed {
        t_byte_op    op;
        logic [7:0]  lead_bits;
        logic [5:0]  cont_bits;
        logic        last;
    } t_queue_entry;

    localparam int QUEUE_WIDTH = $bits(t_queue_entry);

endpackage

### rtl/u8gm_front.sv
// Front: classifies each table byte by its lead-byte pattern.
module u8gm_front
    import u8gm_pkg::*;
(
    input  logic [7:0]   i_table_byte,
    input  logic         i_last_byte,
    output t_queue_entry o_entry
);

    // Lead pattern decode; bit 6 is examined only in the separator match
    always_comb begin
        o_entry.last      = i_last_byte;
        o_entry.cont_bits = i_table_byte[5:0] & CONT_MASK[5:0];
        o_entry.lead_bits = i_table_byte;
        if (i_table_byte == GLYPH_SEP) begin
            o_entry.op = OP_GLYPH;
        end else if (!i_table_byte[7]) begin
            o_entry.op = OP_CHAR1;
        end else if (!i_table_byte[5]) begin
            o_entry.op        = OP_LEAD2;
            o_entry.lead_bits = i_table_byte & LEAD2_MASK;
        end else if (!i_table_byte[4]) begin
            o_entry.op        = OP_LEAD3;
            o_entry.lead_bits = i_table_byte & LEAD3_MASK;
        end else if (!i_table_byte[3]) begin
            o_entry.op        = OP_LEAD4;
            o_entry.lead_bits = i_table_byte & LEAD4_MASK;
        end else begin
            o_entry.op = OP_BADLEAD;
        end
    end

endmodule

### rtl/u8gm_queue.sv
// Small FIFO between front and back.
module u8gm_queue
    import u8gm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int WIDTH = QUEUE_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_not_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full      = (r_count == FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/u8gm_back.sv
// Back: UTF-8 sequence state, glyph counter and output register.
module u8gm_back
    import u8gm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_head_valid,
    input  t_queue_entry i_head,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [15:0]  o_code_point,
    output logic [15:0]  o_glyph_index
);

    logic [15:0] r_glyph_count;
    logic [1:0]  r_bytes_pending;
    logic [15:0] r_partial_code;
    logic        r_out_valid;
    logic [15:0] r_code;
    logic [15:0] r_glyph;

    logic [15:0] n_glyph_count;
    logic [1:0]  n_bytes_pending;
    logic [15:0] n_partial_code;
    logic        n_out_valid;
    logic [15:0] n_code;
    logic        emit;
    logic [15:0] shifted;

    // Take a beat whenever the output slot is free or draining
    assign o_pop = i_head_valid && (!r_out_valid || !i_stall);
    assign shifted = {r_partial_code[9:0], i_head.cont_bits};

    // Decode step
    always_comb begin
        n_glyph_count   = r_glyph_count;
        n_bytes_pending = r_bytes_pending;
        n_partial_code  = r_partial_code;
        n_code          = '0;
        emit            = 1'b0;
        if (r_bytes_pending != 2'd0) begin
            n_partial_code  = shifted;
            n_bytes_pending = r_bytes_pending - 2'd1;
            if (r_bytes_pending == 2'd1) begin
                emit   = 1'b1;
                n_code = shifted;
            end
        end else begin
            case (i_head.op)
                OP_GLYPH: begin
                    n_glyph_count = r_glyph_count + 16'd1;
                end
                OP_CHAR1: begin
                    emit   = 1'b1;
                    n_code = {8'd0, i_head.lead_bits};
                end
                OP_LEAD2: begin
                    n_partial_code  = {8'd0, i_head.lead_bits};
                    n_bytes_pending = 2'd1;
                end
                OP_LEAD3: begin
                    n_partial_code  = {8'd0, i_head.lead_bits};
                    n_bytes_pending = 2'd2;
                end
                OP_LEAD4: begin
                    n_partial_code  = {8'd0, i_head.lead_bits};
                    n_bytes_pending = 2'd3;
                end
                default: begin
                    emit   = 1'b1;
                    n_code = '0;
                end
            endcase
        end
    end

    // Output slot next state
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (o_pop) begin
            n_out_valid = emit;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_count   <= '0;
            r_bytes_pending <= '0;
            r_partial_code  <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                if (i_head.last) begin
                    r_glyph_count   <= '0;
                    r_bytes_pending <= '0;
                    r_partial_code  <= '0;
                end else begin
                    r_glyph_count   <= n_glyph_count;
                    r_bytes_pending <= n_bytes_pending;
                    r_partial_code  <= n_partial_code;
                end
            end
        end
    end

    // Result payload, glyph taken before the last-byte clear
    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_code  <= n_code;
            r_glyph <= r_glyph_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_code_point  = r_code;
    assign o_glyph_index = r_glyph;

endmodule

### rtl/utf8_glyph_map_builder.sv
// A result beat passes through the queue and then the back's output register before it goes valid.
// Throughput: one table byte per cycle while the queue is not full; the back part takes one
// queued byte each cycle while its output register is free or being drained.
// Input stall rises only when the QUEUE_DEPTH-entry queue is full.
// Reset (i_rst_n low, synchronous) clears the glyph counter, sequence state,
// queue and output valid; no clearing pass is needed.
module utf8_glyph_map_builder
    import u8gm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_table_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_point,
    output logic [15:0] o_glyph_index
);

    t_queue_entry front_entry;
    t_queue_entry head_entry;
    logic [QUEUE_WIDTH-1:0] head_bits;
    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;

    assign o_stall    = q_full;
    assign push       = i_valid && !q_full;
    assign head_entry = t_queue_entry'(head_bits);

    u8gm_front u_front (
        .i_table_byte (i_table_byte),
        .i_last_byte  (i_last_byte),
        .o_entry      (front_entry)
    );

    u8gm_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (QUEUE_WIDTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (front_entry),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_data      (head_bits)
    );

    u8gm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (q_not_empty),
        .i_head        (head_entry),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_glyph_index (o_glyph_index)
    );

endmodule

### tb/sv/tb.sv
// Testbench for the UTF-8 glyph map builder: scoreboard, stimulus and checking.
module tb;
    import u8gm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1050;
    localparam int HOLD_CYCLES  = 80;

    // Predicts the map writes from the accepted table bytes
    class glyph_map_scoreboard;
        typedef struct {
            logic [15:0] code;
            logic [15:0] glyph;
        } t_map_write;

        logic [15:0] glyph_count;
        logic [1:0]  bytes_pending;
        logic [15:0] partial_code;
        t_map_write  expected_writes[$];
        int          errors;

        function new();
            glyph_count   = '0;
            bytes_pending = '0;
            partial_code  = '0;
            errors        = 0;
        endfunction

        function int outstanding();
            return expected_writes.size();
        endfunction

        // Advance the decoder by one accepted byte
        function void note_byte(logic [7:0] b, logic last);
            logic [15:0] code;
            bit          hit;
            hit  = 1'b0;
            code = '0;
            if (bytes_pending == 2'd0) begin
                if (b == GLYPH_SEP) begin
                    glyph_count = glyph_count + 16'd1;
                end else if (!b[7]) begin
                    code = {8'h00, b};
                    hit  = 1'b1;
                end else if (!b[5]) begin
                    partial_code  = {8'h00, b & LEAD2_MASK};
                    bytes_pending = 2'd1;
                end else if (!b[4]) begin
                    partial_code  = {8'h00, b & LEAD3_MASK};
                    bytes_pending = 2'd2;
                end else if (!b[3]) begin
                    partial_code  = {8'h00, b & LEAD4_MASK};
                    bytes_pending = 2'd3;
                end else begin
                    // lead byte 0xB8..0xBF or 0xF8..0xFE maps code point zero
                    code = '0;
                    hit  = 1'b1;
                end
            end else begin
                // marker bits of a following byte are ignored
                partial_code  = {partial_code[9:0], b[5:0]};
                bytes_pending = bytes_pending - 2'd1;
                if (bytes_pending == 2'd0) begin
                    code = partial_code;
                    hit  = 1'b1;
                end
            end
            if (hit)
                expected_writes.push_back('{code, glyph_count});
            // end of table drops any partial sequence
            if (last) begin
                glyph_count   = '0;
                bytes_pending = '0;
                partial_code  = '0;
            end
        endfunction

        // Compare one map write with the oldest prediction
        function void check_write(logic [15:0] code, logic [15:0] glyph);
            t_map_write exp_w;
            if (expected_writes.size() == 0) begin
                $error("unexpected map write: code_point %h, glyph_index %h", code, glyph);
                errors++;
                return;
            end
            exp_w = expected_writes.pop_front();
            if (code !== exp_w.code) begin
                $error("code_point mismatch: expected %h, actual %h", exp_w.code, code);
                errors++;
            end
            if (glyph !== exp_w.glyph) begin
                $error("glyph_index mismatch: expected %h, actual %h", exp_w.glyph, glyph);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_table_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_code_point;
    logic [15:0] o_glyph_index;

    glyph_map_scoreboard sb = new();
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int bytes_sent = 0;

    utf8_glyph_map_builder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_table_byte  (i_table_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_glyph_index (o_glyph_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: random stall, plus one long hold-off on request
    initial begin : receiver
        int held;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                held = 1;
                while (held < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else begin
                i_stall <= idle_on && ($urandom_range(99) < 6);
            end
        end
    end

    // Map write monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_write(o_code_point, o_glyph_index);
    end

    // Offer one byte beat and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_table_byte <= b;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic rand_last();
        return $urandom_range(199) == 0;
    endfunction

    // One random table unit: mostly well-formed characters and separators
    task automatic send_random_unit();
        int          kind;
        int          n_follow;
        logic [7:0]  lead;
        logic [7:0]  b6;
        logic [7:0]  cont;
        kind     = $urandom_range(99);
        n_follow = 0;
        b6       = ($urandom_range(9) != 0) ? 8'h40 : 8'h00;
        if (kind < 25) begin
            lead = 8'($urandom_range(127));
        end else if (kind < 45) begin
            lead = 8'h80 | b6 | 8'($urandom_range(31));
            n_follow = 1;
        end else if (kind < 60) begin
            lead = 8'hA0 | b6 | 8'($urandom_range(15));
            n_follow = 2;
        end else if (kind < 72) begin
            lead = 8'hB0 | b6 | 8'($urandom_range(7));
            n_follow = 3;
        end else if (kind < 84) begin
            lead = GLYPH_SEP;
        end else if (kind < 88) begin
            lead = 8'hF8 + 8'($urandom_range(6));
        end else begin
            lead = 8'($urandom_range(255));
        end
        send_byte(lead, rand_last());
        for (int i = 0; i < n_follow; i++) begin
            cont = ($urandom_range(9) != 0) ? (8'h80 | 8'($urandom_range(63)))
                                            : 8'($urandom_range(255));
            send_byte(cont, rand_last());
        end
    endtask

    initial begin : stimulus
        int start_count;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_table_byte = '0;
        i_last_byte  = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ASCII extremes, separator, each sequence length
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(GLYPH_SEP, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(GLYPH_SEP, 1'b0);
        // four-byte code truncated to 16 bits
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // invalid leads give code point zero
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFE, 1'b0);
        // 0xFF inside a sequence is a following byte
        send_byte(8'hC2, 1'b0);
        send_byte(GLYPH_SEP, 1'b0);
        // lead with bit 6 clear, follower without marker bits
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
        // end of table in mid-sequence drops it
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        // end of table on a character still writes it
        send_byte(8'h41, 1'b1);
        send_byte(GLYPH_SEP, 1'b1);
        wait_drained();

        // Characters on both sides of a separator, table end on a character
        send_byte(8'h41, 1'b0);
        send_byte(GLYPH_SEP, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b1);

        // Random tables
        start_count = bytes_sent;
        while (bytes_sent < start_count + RANDOM_BYTES) begin
            if (bytes_sent - start_count >= 300 && bytes_sent - start_count < 305
                    && !hold_req)
                hold_req = 1'b1;
            if (bytes_sent - start_count >= 500 && bytes_sent - start_count < 505)
                wait_drained();
            idle_on = !(bytes_sent - start_count >= 600 && bytes_sent - start_count < 800);
            send_random_unit();
        end
        idle_on = 1'b1;

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
